[rtl/ctu_pkg.sv]
// Shared types and constants of the control transfer unit.
package ctu_pkg;

	localparam logic [6:0] OP_JAL    = 7'b1101111;
	localparam logic [6:0] OP_JALR   = 7'b1100111;
	localparam logic [6:0] OP_AUIPC  = 7'b0010111;
	localparam logic [6:0] OP_BRANCH = 7'b1100011;

	localparam logic [2:0] F3_JALR = 3'b000;
	localparam logic [2:0] F3_BEQ  = 3'b000;
	localparam logic [2:0] F3_BNE  = 3'b001;
	localparam logic [2:0] F3_BLT  = 3'b100;
	localparam logic [2:0] F3_BGE  = 3'b101;
	localparam logic [2:0] F3_BLTU = 3'b110;
	localparam logic [2:0] F3_BGEU = 3'b111;

	localparam logic [1:0] STATUS_DONE    = 2'd0;
	localparam logic [1:0] STATUS_RSV_F3  = 2'd1;
	localparam logic [1:0] STATUS_UNSUP   = 2'd2;

	localparam int unsigned LINK_STEP = 4;

	typedef enum logic [2:0] {
		KIND_JAL,
		KIND_JALR,
		KIND_AUIPC,
		KIND_BRANCH,
		KIND_BAD_BRANCH,
		KIND_UNSUP
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  funct3;
		logic [4:0]  rd;
		logic [31:0] imm;
	} ctrl_t;

endpackage

[rtl/riscv_control_transfer_unit.sv]
// Top level of the control transfer unit: input and result registers around the execute logic.
//
// Channel   Direction  Handshake                 Fields
// command   in         start && !busy            instruction, pc, rs1_value, rs2_value
// result    out        done (one-cycle strobe)   next_pc, rd_write, rd_addr, rd_value, status
//
// One instruction can be taken every cycle; busy is never raised.
// The result of a transfer appears with done after the input register and then the result register.
// arst_n clears the valid flags of both stages; payload registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
module riscv_control_transfer_unit
	import ctu_pkg::*;
#(
	parameter int XLEN = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [31:0]     instruction,
	input  logic [XLEN-1:0] pc,
	input  logic [XLEN-1:0] rs1_value,
	input  logic [XLEN-1:0] rs2_value,
	output logic            done,
	output logic [XLEN-1:0] next_pc,
	output logic            rd_write,
	output logic [4:0]      rd_addr,
	output logic [XLEN-1:0] rd_value,
	output logic [1:0]      status
);

	logic            accept;
	logic            valid_s1;
	logic [31:0]     instr_s1;
	logic [XLEN-1:0] pc_s1;
	logic [XLEN-1:0] rs1_s1;
	logic [XLEN-1:0] rs2_s1;
	ctrl_t           ctrl;
	logic [XLEN-1:0] exe_next_pc;
	logic            exe_rd_write;
	logic [XLEN-1:0] exe_rd_value;
	logic [1:0]      exe_status;
	logic            valid_s2;
	logic [XLEN-1:0] next_pc_s2;
	logic            rd_write_s2;
	logic [4:0]      rd_addr_s2;
	logic [XLEN-1:0] rd_value_s2;
	logic [1:0]      status_s2;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instruction;
			pc_s1    <= pc;
			rs1_s1   <= rs1_value;
			rs2_s1   <= rs2_value;
		end
	end

	ctu_decode u_decode (
		.instruction (instr_s1),
		.ctrl        (ctrl)
	);

	ctu_exec #(
		.XLEN (XLEN)
	) u_exec (
		.ctrl      (ctrl),
		.pc        (pc_s1),
		.rs1_value (rs1_s1),
		.rs2_value (rs2_s1),
		.next_pc   (exe_next_pc),
		.rd_write  (exe_rd_write),
		.rd_value  (exe_rd_value),
		.status    (exe_status)
	);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			next_pc_s2  <= exe_next_pc;
			rd_write_s2 <= exe_rd_write;
			rd_addr_s2  <= ctrl.rd;
			rd_value_s2 <= exe_rd_value;
			status_s2   <= exe_status;
		end
	end

	assign done     = valid_s2;
	assign next_pc  = next_pc_s2;
	assign rd_write = rd_write_s2;
	assign rd_addr  = rd_addr_s2;
	assign rd_value = rd_value_s2;
	assign status   = status_s2;

	// Every transfer taken comes out with done, after the input and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("accepted transfer did not produce a result");

	// A failed instruction never writes a register and leaves the pc alone.
	a_fail_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STATUS_DONE) |-> (!rd_write && next_pc == $past(pc_s1)))
		else $error("failed instruction changed state");

	// x0 is never written.
	a_no_x0: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rd_write) |-> (rd_addr != 5'd0))
		else $error("write to x0");

endmodule

[rtl/ctu_decode.sv]
// Instruction decoder: operation kind, destination and immediate.
module ctu_decode
	import ctu_pkg::*;
(
	input  logic [31:0] instruction,
	output ctrl_t       ctrl
);

	logic [6:0]  opcode;
	logic [2:0]  funct3;
	logic [31:0] imm_i;
	logic [31:0] imm_u;
	logic [31:0] imm_j;
	logic [31:0] imm_b;

	assign opcode = instruction[6:0];
	assign funct3 = instruction[14:12];

	assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
	assign imm_u = {instruction[31:12], 12'b0};
	assign imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
		instruction[20], instruction[30:21], 1'b0};
	assign imm_b = {{19{instruction[31]}}, instruction[31], instruction[7],
		instruction[30:25], instruction[11:8], 1'b0};

	always_comb begin
		ctrl.funct3 = funct3;
		ctrl.rd     = instruction[11:7];
		ctrl.kind   = KIND_UNSUP;
		ctrl.imm    = imm_i;
		case (opcode)
			OP_JAL: begin
				ctrl.kind = KIND_JAL;
				ctrl.imm  = imm_j;
			end
			OP_JALR: begin
				// Only funct3 zero is a valid JALR encoding.
				ctrl.kind = (funct3 == F3_JALR) ? KIND_JALR : KIND_UNSUP;
				ctrl.imm  = imm_i;
			end
			OP_AUIPC: begin
				ctrl.kind = KIND_AUIPC;
				ctrl.imm  = imm_u;
			end
			OP_BRANCH: begin
				ctrl.imm = imm_b;
				case (funct3)
					F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU: begin
						ctrl.kind = KIND_BRANCH;
					end
					default: begin
						ctrl.kind = KIND_BAD_BRANCH;
					end
				endcase
			end
			default: begin
				ctrl.kind = KIND_UNSUP;
			end
		endcase
	end

endmodule

[rtl/ctu_exec.sv]
// Execute logic: branch compare, target and link adders, result select.
module ctu_exec
	import ctu_pkg::*;
#(
	parameter int XLEN = 64
) (
	input  ctrl_t           ctrl,
	input  logic [XLEN-1:0] pc,
	input  logic [XLEN-1:0] rs1_value,
	input  logic [XLEN-1:0] rs2_value,
	output logic [XLEN-1:0] next_pc,
	output logic            rd_write,
	output logic [XLEN-1:0] rd_value,
	output logic [1:0]      status
);

	logic [XLEN-1:0] imm_x;
	logic [XLEN-1:0] base;
	logic [XLEN-1:0] target;
	logic [XLEN-1:0] pc_link;
	logic            eq;
	logic            lt;
	logic            ltu;
	logic            take;
	logic            wr;

	assign imm_x   = XLEN'($signed(ctrl.imm));
	assign base    = (ctrl.kind == KIND_JALR) ? rs1_value : pc;
	assign target  = base + imm_x;
	assign pc_link = pc + XLEN'(LINK_STEP);

	assign eq  = (rs1_value == rs2_value);
	assign lt  = ($signed(rs1_value) < $signed(rs2_value));
	assign ltu = (rs1_value < rs2_value);

	always_comb begin
		case (ctrl.funct3)
			F3_BEQ:  take = eq;
			F3_BNE:  take = !eq;
			F3_BLT:  take = lt;
			F3_BGE:  take = !lt;
			F3_BLTU: take = ltu;
			F3_BGEU: take = !ltu;
			default: take = 1'b0;
		endcase
	end

	always_comb begin
		next_pc  = pc;
		wr       = 1'b0;
		rd_value = '0;
		status   = STATUS_DONE;
		case (ctrl.kind)
			KIND_JAL: begin
				next_pc  = target;
				wr       = 1'b1;
				rd_value = pc_link;
			end
			KIND_JALR: begin
				next_pc  = {target[XLEN-1:1], 1'b0};
				wr       = 1'b1;
				rd_value = pc_link;
			end
			KIND_AUIPC: begin
				next_pc  = pc_link;
				wr       = 1'b1;
				rd_value = target;
			end
			KIND_BRANCH: begin
				next_pc = take ? target : pc_link;
			end
			KIND_BAD_BRANCH: begin
				status = STATUS_RSV_F3;
			end
			default: begin
				status = STATUS_UNSUP;
			end
		endcase
		// Writes to x0 are dropped along with their value.
		if (ctrl.rd == 5'd0) begin
			wr       = 1'b0;
			rd_value = '0;
		end
	end

	assign rd_write = wr;

endmodule
